>>> rtl/core/lodc_pkg.sv
`default_nettype none

package lodc_pkg;

  // result codes
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_MULTI_UNLOCK   = 3'd1,
    ST_INVALID_UNLOCK = 3'd2,
    ST_DEADLOCK       = 3'd3,
    ST_STACK_FULL     = 3'd4,
    ST_HALTED         = 3'd5
  } status_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_READ_PREV,
    OP_ADD_EDGE,
    OP_START_SKIP,
    OP_START_VISIT,
    OP_DESCEND,
    OP_PROBE,
    OP_RETIRE,
    OP_POP,
    OP_RESUME,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t code;
    logic    push;
    logic    pop;
    logic    set_halt;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic acquire;
    logic cnt_full;
    logic cnt_zero;
    logic top_eq_lk;
    logic edge_set;
    logic s_end;
    logic s_visited;
    logic t_found;
    logic t_visited;
    logic sp_last;
    logic order_less;
    logic t_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/lock_order_deadlock_checker_core.sv
`default_nettype none

// channel   signals                              transfer when
// event     event_valid event_stall kind         event_valid && !event_stall
//           thread lock_id
// result    result_valid result_stall status     result_valid && !result_stall
//           new_edge edge_from edge_to
//
// an event is settled from the stack top alone, or also from a read of the
// graph row of the previous lock when the order edge already exists; a new
// edge adds a depth-first walk over start nodes, new nodes, visited-node
// probes and pops, all through the single graph read port
// reset is synchronous and clears the graph valid bits, counts and halted flag
// a stalled result lets the next event in but holds its finish until the
// output register empties

module lock_order_deadlock_checker_core
  import lodc_pkg::*;
#(
  parameter int LOCKS       = 32,
  parameter int THREADS     = 4,
  parameter int STACK_DEPTH = 16
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        event_valid,
  output logic       event_stall,
  input  wire        kind,
  input  wire  [1:0] thread,
  input  wire  [4:0] lock_id,
  output logic       result_valid,
  input  wire        result_stall,
  output logic [2:0] status,
  output logic       new_edge,
  output logic [4:0] edge_from,
  output logic [4:0] edge_to
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  lodc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  // stacks, graph and walk
  lodc_datapath #(
    .LOCKS       (LOCKS),
    .THREADS     (THREADS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .kind         (kind),
    .thread       (thread),
    .lock_id      (lock_id),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .new_edge     (new_edge),
    .edge_from    (edge_from),
    .edge_to      (edge_to),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

`default_nettype wire

>>> rtl/core/lodc_ctrl.sv
`default_nettype none

module lodc_ctrl
  import lodc_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   event_valid,
  output logic  event_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_EDGE,
    S_WSTART,
    S_WSCAN,
    S_WCMP,
    S_WPOP,
    S_FIN
  } state_t;

  state_t state, state_next;
  cmd_t   pend, pend_next;

  function automatic cmd_t mk_fin(status_t code, logic push, logic pop, logic halt);
    cmd_t c;
    c.op       = OP_FINISH;
    c.code     = code;
    c.push     = push;
    c.pop      = pop;
    c.set_halt = halt;
    return c;
  endfunction

  function automatic cmd_t mk_op(op_t op);
    cmd_t c;
    c.op       = op;
    c.code     = ST_OK;
    c.push     = 1'b0;
    c.pop      = 1'b0;
    c.set_halt = 1'b0;
    return c;
  endfunction

  // next state and command
  always_comb begin
    cmd_t fin;
    fin        = mk_op(OP_NONE);
    cmd        = mk_op(OP_NONE);
    state_next = state;
    pend_next  = pend;
    case (state)
      S_IDLE: begin
        if (event_valid) begin
          cmd        = mk_op(OP_LATCH);
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        if (stat.halted) begin
          fin = mk_fin(ST_HALTED, 1'b0, 1'b0, 1'b0);
        end else if (stat.acquire) begin
          if (stat.cnt_full) begin
            fin = mk_fin(ST_STACK_FULL, 1'b0, 1'b0, 1'b0);
          end else if (stat.cnt_zero || stat.top_eq_lk) begin
            fin = mk_fin(ST_OK, 1'b1, 1'b0, 1'b0);
          end
        end else if (stat.cnt_zero) begin
          fin = mk_fin(ST_MULTI_UNLOCK, 1'b0, 1'b0, 1'b1);
        end else if (!stat.top_eq_lk) begin
          fin = mk_fin(ST_INVALID_UNLOCK, 1'b0, 1'b0, 1'b1);
        end else begin
          fin = mk_fin(ST_OK, 1'b0, 1'b1, 1'b0);
        end
        if (fin.op == OP_NONE) begin
          cmd        = mk_op(OP_READ_PREV);
          state_next = S_EDGE;
        end
      end
      S_EDGE: begin
        if (stat.edge_set) begin
          fin = mk_fin(ST_OK, 1'b1, 1'b0, 1'b0);
        end else begin
          cmd        = mk_op(OP_ADD_EDGE);
          state_next = S_WSTART;
        end
      end
      S_WSTART: begin
        if (stat.s_end) begin
          fin = mk_fin(ST_OK, 1'b1, 1'b0, 1'b0);
        end else if (stat.s_visited) begin
          cmd = mk_op(OP_START_SKIP);
        end else begin
          cmd        = mk_op(OP_START_VISIT);
          state_next = S_WSCAN;
        end
      end
      S_WSCAN: begin
        if (!stat.t_found) begin
          if (stat.sp_last) begin
            cmd        = mk_op(OP_RETIRE);
            state_next = S_WSTART;
          end else begin
            cmd        = mk_op(OP_POP);
            state_next = S_WPOP;
          end
        end else if (!stat.t_visited) begin
          cmd = mk_op(OP_DESCEND);
        end else begin
          cmd        = mk_op(OP_PROBE);
          state_next = S_WCMP;
        end
      end
      S_WCMP: begin
        if (!stat.order_less && !stat.t_done) begin
          fin = mk_fin(ST_DEADLOCK, 1'b0, 1'b0, 1'b1);
        end else begin
          state_next = S_WSCAN;
        end
      end
      S_WPOP: begin
        cmd        = mk_op(OP_RESUME);
        state_next = S_WSCAN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd        = pend;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // hand the result over now, or hold it until the output is free
    if (fin.op == OP_FINISH) begin
      if (stat.out_free) begin
        cmd        = fin;
        state_next = S_IDLE;
      end else begin
        pend_next  = fin;
        state_next = S_FIN;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      event_stall <= 1'b0;
      pend        <= mk_op(OP_NONE);
    end else begin
      state       <= state_next;
      event_stall <= (state_next != S_IDLE);
      pend        <= pend_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lodc_datapath.sv
`default_nettype none

module lodc_datapath
  import lodc_pkg::*;
#(
  parameter int LOCKS       = 32,
  parameter int THREADS     = 4,
  parameter int STACK_DEPTH = 16
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        kind,
  input  wire  [1:0] thread,
  input  wire  [4:0] lock_id,
  output logic       result_valid,
  input  wire        result_stall,
  output logic [2:0] status,
  output logic       new_edge,
  output logic [4:0] edge_from,
  output logic [4:0] edge_to,
  input  cmd_t       cmd,
  output stat_t      stat
);

  localparam int LW = $clog2(LOCKS);
  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int FW = 3 * LW + 1;

  // modulo tables for incoming thread and lock numbers
  logic [TW-1:0] th_tab [4];
  logic [LW-1:0] lk_tab [32];
  for (genvar i = 0; i < 4; i++) begin : g_th_tab
    assign th_tab[i] = TW'(i % THREADS);
  end
  for (genvar i = 0; i < 32; i++) begin : g_lk_tab
    assign lk_tab[i] = LW'(i % LOCKS);
  end

  // event registers and per-thread state
  logic          ev_kind;
  logic [TW-1:0] ev_th;
  logic [LW-1:0] ev_lk;
  logic [CW-1:0] cnt [THREADS];
  logic          halted;
  logic          newe;

  // memories
  logic [LW-1:0]    hs_mem [THREADS][STACK_DEPTH];
  logic [LW-1:0]    hs_rdata;
  logic [LOCKS-1:0] g_mem [LOCKS];
  logic [LOCKS-1:0] g_valid;
  logic [LOCKS-1:0] g_rdata;
  logic             g_rvalid;
  logic [LW-1:0]    vo_mem [LOCKS];
  logic [LW-1:0]    vo_rdata;
  logic [FW-1:0]    ws_mem [LOCKS];
  logic [FW-1:0]    ws_rdata;

  // walk registers
  logic [LOCKS-1:0] visited;
  logic [LOCKS-1:0] done_mark;
  logic [LW-1:0]    top_node;
  logic [LW:0]      top_cur;
  logic [LW-1:0]    top_ord;
  logic [LW:0]      sp;
  logic [LW:0]      s;
  logic [LW:0]      count;
  logic [LW-1:0]    t_hold;

  // derived values
  logic [TW-1:0]    in_th;
  logic [CW-1:0]    in_cnt_m1;
  logic [CW-1:0]    cur_cnt;
  logic [LOCKS-1:0] row;
  logic [LOCKS-1:0] cand;
  logic             t_found;
  logic [LW-1:0]    t_first;
  logic [LW:0]      t_next;
  logic             sp_room;
  logic [LW:0]      sp_m1;
  logic [LW:0]      sp_m2;
  logic [LW-1:0]    s_idx;
  logic [LW-1:0]    ws_node;
  logic             g_re;
  logic [LW-1:0]    g_raddr;
  logic             g_we;
  logic             out_free;
  logic             fin;

  assign in_th     = th_tab[thread];
  assign in_cnt_m1 = cnt[in_th] - CW'(1);
  assign cur_cnt   = cnt[ev_th];
  assign row       = g_rvalid ? g_rdata : '0;
  assign s_idx     = s[LW-1:0];
  assign sp_m1     = sp - (LW+1)'(1);
  assign sp_m2     = sp - (LW+1)'(2);
  assign sp_room   = (sp < (LW+1)'(LOCKS));
  assign t_next    = (LW+1)'(t_first) + (LW+1)'(1);
  assign ws_node   = ws_rdata[FW-1 -: LW];
  assign out_free  = !result_valid || !result_stall;
  assign fin       = (cmd.op == OP_FINISH);

  // first neighbour at or above the cursor
  always_comb begin
    t_found = 1'b0;
    t_first = '0;
    for (int i = 0; i < LOCKS; i++) begin
      cand[i] = row[i] && ((LW+1)'(i) >= top_cur);
    end
    for (int i = LOCKS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        t_found = 1'b1;
        t_first = LW'(i);
      end
    end
  end

  // order graph read port selection
  always_comb begin
    g_re    = 1'b0;
    g_raddr = '0;
    g_we    = (cmd.op == OP_ADD_EDGE);
    case (cmd.op)
      OP_READ_PREV: begin
        g_re    = 1'b1;
        g_raddr = hs_rdata;
      end
      OP_START_VISIT: begin
        g_re    = 1'b1;
        g_raddr = s_idx;
      end
      OP_DESCEND: begin
        g_re    = sp_room;
        g_raddr = t_first;
      end
      OP_RESUME: begin
        g_re    = 1'b1;
        g_raddr = ws_node;
      end
      default: begin
        g_re = 1'b0;
      end
    endcase
  end

  // status towards the controller
  always_comb begin
    stat.halted     = halted;
    stat.acquire    = !ev_kind;
    stat.cnt_full   = (cur_cnt >= CW'(STACK_DEPTH));
    stat.cnt_zero   = (cur_cnt == '0);
    stat.top_eq_lk  = (hs_rdata == ev_lk);
    stat.edge_set   = row[ev_lk];
    stat.s_end      = (s == (LW+1)'(LOCKS));
    stat.s_visited  = visited[s_idx];
    stat.t_found    = t_found;
    stat.t_visited  = visited[t_first];
    stat.sp_last    = (sp == (LW+1)'(1));
    stat.order_less = (top_ord < vo_rdata);
    stat.t_done     = done_mark[t_hold];
    stat.out_free   = out_free;
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      hs_rdata <= hs_mem[in_th][in_cnt_m1[SW-1:0]];
    end
    if (fin && cmd.push) begin
      hs_mem[ev_th][cur_cnt[SW-1:0]] <= ev_lk;
    end
    if (g_we) begin
      g_mem[hs_rdata] <= row | (LOCKS'(1) << ev_lk);
    end
    if (g_re) begin
      g_rdata <= g_mem[g_raddr];
    end
    if (cmd.op == OP_START_VISIT) begin
      vo_mem[s_idx] <= LW'(count);
    end
    if (cmd.op == OP_DESCEND) begin
      vo_mem[t_first] <= LW'(count);
      if (sp_room) begin
        ws_mem[sp_m1[LW-1:0]] <= {top_node, t_next, top_ord};
      end
    end
    if (cmd.op == OP_PROBE) begin
      vo_rdata <= vo_mem[t_first];
    end
    if (cmd.op == OP_POP) begin
      ws_rdata <= ws_mem[sp_m2[LW-1:0]];
    end
  end

  // event and walk payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      case (cmd.op)
        OP_LATCH: begin
          ev_kind <= kind;
          ev_th   <= in_th;
          ev_lk   <= lk_tab[lock_id];
        end
        OP_ADD_EDGE: begin
          s     <= '0;
          count <= '0;
        end
        OP_START_SKIP: begin
          s <= s + (LW+1)'(1);
        end
        OP_START_VISIT: begin
          top_node <= s_idx;
          top_cur  <= '0;
          top_ord  <= LW'(count);
          count    <= count + (LW+1)'(1);
          sp       <= (LW+1)'(1);
        end
        OP_DESCEND: begin
          count <= count + (LW+1)'(1);
          if (sp_room) begin
            top_node <= t_first;
            top_cur  <= '0;
            top_ord  <= LW'(count);
            sp       <= sp + (LW+1)'(1);
          end else begin
            top_cur <= t_next;
          end
        end
        OP_PROBE: begin
          top_cur <= t_next;
          t_hold  <= t_first;
        end
        OP_RETIRE: begin
          sp <= '0;
          s  <= s + (LW+1)'(1);
        end
        OP_POP: begin
          sp <= sp_m1;
        end
        OP_RESUME: begin
          top_node <= ws_node;
          top_cur  <= ws_rdata[2*LW -: LW+1];
          top_ord  <= ws_rdata[LW-1:0];
        end
        OP_FINISH: begin
          status <= cmd.code;
          new_edge <= newe;
          if (cmd.code == ST_DEADLOCK) begin
            edge_from <= 5'(top_node);
            edge_to   <= 5'(t_hold);
          end else begin
            edge_from <= '0;
            edge_to   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREADS; i++) begin
        cnt[i] <= '0;
      end
      halted       <= 1'b0;
      newe         <= 1'b0;
      g_valid      <= '0;
      g_rvalid     <= 1'b0;
      visited      <= '0;
      done_mark    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (g_re) begin
        g_rvalid <= g_valid[g_raddr];
      end
      case (cmd.op)
        OP_LATCH: begin
          newe <= 1'b0;
        end
        OP_ADD_EDGE: begin
          g_valid[hs_rdata] <= 1'b1;
          newe              <= 1'b1;
          visited           <= '0;
          done_mark         <= '0;
        end
        OP_START_VISIT: begin
          visited[s_idx] <= 1'b1;
        end
        OP_DESCEND: begin
          visited[t_first] <= 1'b1;
        end
        OP_RETIRE, OP_POP: begin
          done_mark[top_node] <= 1'b1;
        end
        OP_FINISH: begin
          if (cmd.push) begin
            cnt[ev_th] <= cur_cnt + CW'(1);
          end
          if (cmd.pop) begin
            cnt[ev_th] <= cur_cnt - CW'(1);
          end
          if (cmd.set_halt) begin
            halted <= 1'b1;
          end
        end
        default: begin
        end
      endcase
      // output register: a finish loads it, a transfer empties it
      if (fin) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halted flag cleared");
  a_fin_free: assert property (@(posedge clk) disable iff (rst) fin |-> out_free)
    else $error("result overwritten while stalled");
  a_sp_bound: assert property (@(posedge clk) disable iff (rst) sp <= (LW+1)'(LOCKS))
    else $error("walk stack pointer out of range");
  a_rose_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(fin))
    else $error("result without finish");
`endif

endmodule

`default_nettype wire

>>> verif/tb_lock_order_deadlock_checker_core.sv
`timescale 1ns / 1ps

module tb_lock_order_deadlock_checker_core
  import lodc_pkg::*;
();

  localparam int LOCKS = 32;
  localparam int THREADS = 4;
  localparam int STACK_DEPTH = 16;
  localparam int IDLE_LIMIT = 20000;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [1:0] thread;
    logic [4:0] lock_id;
  } lock_event_t;

  typedef struct packed {
    status_t    status;
    logic       new_edge;
    logic [4:0] edge_from;
    logic [4:0] edge_to;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic event_valid = 1'b0;
  logic kind = 1'b0;
  logic [1:0] thread = '0;
  logic [4:0] lock_id = '0;
  logic result_stall = 1'b0;
  wire event_stall;
  wire result_valid;
  wire [2:0] status;
  wire new_edge;
  wire [4:0] edge_from;
  wire [4:0] edge_to;

  lock_order_deadlock_checker_core u_dut (
    .clk(clk), .rst(rst),
    .event_valid(event_valid), .event_stall(event_stall),
    .kind(kind), .thread(thread), .lock_id(lock_id),
    .result_valid(result_valid), .result_stall(result_stall),
    .status(status), .new_edge(new_edge),
    .edge_from(edge_from), .edge_to(edge_to)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow state of the checker
  logic [LOCKS-1:0] order_rows [LOCKS];
  logic [4:0] held_locks [THREADS][STACK_DEPTH];
  int held_depth [THREADS];
  logic is_halted;

  lock_event_t pending_events[$];
  verdict_t expected_verdicts[$];
  int errors = 0;
  bit stimulus_done = 1'b0;

  task automatic clear_shadow();
    for (int i = 0; i < LOCKS; i++) order_rows[i] = '0;
    for (int i = 0; i < THREADS; i++) held_depth[i] = 0;
    is_halted = 1'b0;
  endtask

  // depth-first cycle search, ascending starts and neighbours
  function automatic bit search_cycle(output logic [4:0] bf, output logic [4:0] bt);
    int order_no [LOCKS];
    bit seen [LOCKS];
    bit retired [LOCKS];
    int node_stk [LOCKS];
    int cur_stk [LOCKS];
    int sp, h, t, count;
    count = 0;
    bf = '0;
    bt = '0;
    for (int i = 0; i < LOCKS; i++) begin
      seen[i] = 0; retired[i] = 0; order_no[i] = 0;
    end
    for (int s = 0; s < LOCKS; s++) begin
      if (seen[s]) continue;
      seen[s] = 1;
      order_no[s] = count++;
      node_stk[0] = s;
      cur_stk[0] = 0;
      sp = 1;
      while (sp > 0) begin
        h = node_stk[sp-1];
        t = cur_stk[sp-1];
        while (t < LOCKS && !order_rows[h][t]) t++;
        if (t >= LOCKS) begin
          retired[h] = 1;
          sp--;
          continue;
        end
        cur_stk[sp-1] = t + 1;
        if (!seen[t]) begin
          seen[t] = 1;
          order_no[t] = count++;
          if (sp < LOCKS) begin
            node_stk[sp] = t;
            cur_stk[sp] = 0;
            sp++;
          end
          continue;
        end
        if (order_no[h] < order_no[t]) continue;
        if (!retired[t]) begin
          bf = h[4:0];
          bt = t[4:0];
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // work out the verdict of one event and advance the shadow state
  function automatic verdict_t predict_verdict(lock_event_t ev);
    verdict_t v;
    int th, cnt;
    logic [4:0] prev, bf, bt;
    bit dead;
    v = '{status: ST_OK, new_edge: 1'b0, edge_from: '0, edge_to: '0};
    th = int'(ev.thread);
    cnt = held_depth[th];
    dead = 0;
    if (is_halted) begin
      v.status = ST_HALTED;
    end else if (ev.kind == KIND_ACQUIRE) begin
      if (cnt >= STACK_DEPTH) begin
        v.status = ST_STACK_FULL;
      end else begin
        if (cnt > 0) begin
          prev = held_locks[th][cnt-1];
          if (prev != ev.lock_id && !order_rows[prev][ev.lock_id]) begin
            order_rows[prev][ev.lock_id] = 1'b1;
            v.new_edge = 1'b1;
            if (search_cycle(bf, bt)) begin
              dead = 1;
              v.status = ST_DEADLOCK;
              v.edge_from = bf;
              v.edge_to = bt;
              is_halted = 1'b1;
            end
          end
        end
        if (!dead) begin
          held_locks[th][cnt] = ev.lock_id;
          held_depth[th] = cnt + 1;
        end
      end
    end else begin
      if (cnt == 0) begin
        v.status = ST_MULTI_UNLOCK;
        is_halted = 1'b1;
      end else if (held_locks[th][cnt-1] != ev.lock_id) begin
        v.status = ST_INVALID_UNLOCK;
        is_halted = 1'b1;
      end else begin
        held_depth[th] = cnt - 1;
      end
    end
    return v;
  endfunction

  task automatic add_event(logic k, int th, int lk);
    lock_event_t ev;
    ev.kind = k;
    ev.thread = th[1:0];
    ev.lock_id = lk[4:0];
    pending_events.push_back(ev);
  endtask

  // well-formed nested acquire then release in reverse
  task automatic add_nested(int th, int n, int base, int step);
    for (int i = 0; i < n; i++) add_event(KIND_ACQUIRE, th, (base + i * step) % LOCKS);
    for (int i = n - 1; i >= 0; i--) add_event(KIND_RELEASE, th, (base + i * step) % LOCKS);
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (event_valid && event_stall) begin
      // hold the stalled transfer
    end else begin
      if (event_valid)
        expected_verdicts.push_back(predict_verdict('{kind, thread, lock_id}));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        event_valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        lock_event_t ev;
        ev = pending_events.pop_front();
        event_valid <= 1'b1;
        kind <= ev.kind;
        thread <= ev.thread;
        lock_id <= ev.lock_id;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end else begin
        event_valid <= 1'b0;
      end
    end
  end

  // monitor and stall pattern
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, status);
        errors++;
      end else begin
        verdict_t exp_v;
        exp_v = expected_verdicts.pop_front();
        if (status !== exp_v.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_v.status, status);
        if (new_edge !== exp_v.new_edge)
          $display("%0t: new_edge expected %0d actual %0d", $time, exp_v.new_edge, new_edge);
        if (edge_from !== exp_v.edge_from)
          $display("%0t: edge_from expected %0d actual %0d", $time, exp_v.edge_from, edge_from);
        if (edge_to !== exp_v.edge_to)
          $display("%0t: edge_to expected %0d actual %0d", $time, exp_v.edge_to, edge_to);
        if (status !== exp_v.status || new_edge !== exp_v.new_edge ||
            edge_from !== exp_v.edge_from || edge_to !== exp_v.edge_to)
          errors++;
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (result_valid && !result_stall && $urandom_range(0, 2) != 0) begin
      stall_left <= $urandom_range(0, 19);
      result_stall <= 1'b0;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((event_valid && !event_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !stimulus_done) begin
      $display("lock_order_deadlock_checker_core test failed");
      $finish;
    end
  end

  // segments separated by a reset are impossible, so each segment of
  // stimulus lives until the first fatal error; the bulk is well-formed
  initial begin
    int th, n, base;
    clear_shadow();
    // directed: extremes, push same lock, existing edge, stack full
    add_event(KIND_ACQUIRE, 3, 31);
    add_event(KIND_ACQUIRE, 3, 31);
    add_event(KIND_ACQUIRE, 3, 0);
    add_event(KIND_RELEASE, 3, 0);
    add_event(KIND_ACQUIRE, 3, 0);
    add_event(KIND_RELEASE, 3, 0);
    add_event(KIND_RELEASE, 3, 31);
    add_event(KIND_RELEASE, 3, 31);
    for (int i = 0; i < STACK_DEPTH; i++) add_event(KIND_ACQUIRE, 0, 5);
    add_event(KIND_ACQUIRE, 0, 6);
    for (int i = 0; i < STACK_DEPTH; i++) add_event(KIND_RELEASE, 0, 5);
    // random well-formed nesting with an ascending lock order: no cycle
    for (int i = 0; i < 275; i++) begin
      th = $urandom_range(0, 3);
      n = $urandom_range(1, 5);
      base = $urandom_range(0, 31 - n);
      add_nested(th, n, base, 1);
      if ($urandom_range(0, 9) == 0) add_nested(th, $urandom_range(1, 3), $urandom_range(0, 8), 7);
      if (i == 150) begin
        // thread 2 takes 21 then 20, which closes a cycle with the edge from 20 to 21
        add_nested(1, 2, 20, 1);
        add_event(KIND_ACQUIRE, 2, 21);
        add_event(KIND_ACQUIRE, 2, 20);
        add_event(KIND_RELEASE, 1, 7);
        add_event(KIND_ACQUIRE, 0, 1);
      end
    end
    // noise after halting, all bits of all fields
    for (int i = 0; i < 60; i++)
      add_event(1'($urandom_range(0, 1)), $urandom_range(0, 3), $urandom_range(0, 31));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending_events.size() == 0);
    @(posedge clk);
    while (event_valid) @(posedge clk);
    fork
      begin
        while (expected_verdicts.size() > 0) @(posedge clk);
        repeat (4000) @(posedge clk);
      end
      begin
        repeat (IDLE_LIMIT * 4) @(posedge clk);
        $display("lock_order_deadlock_checker_core test failed");
        $finish;
      end
    join_any
    stimulus_done = 1'b1;
    if (errors == 0 && expected_verdicts.size() == 0)
      $display("lock_order_deadlock_checker_core test passed");
    else
      $display("lock_order_deadlock_checker_core test failed");
    $finish;
  end

endmodule

>>> lock_order_deadlock_checker_core.f
rtl/core/lodc_pkg.sv
rtl/core/lodc_ctrl.sv
rtl/core/lodc_datapath.sv
rtl/core/lock_order_deadlock_checker_core.sv
verif/tb_lock_order_deadlock_checker_core.sv
